### sv/c2p_pkg.sv
`default_nettype none

package c2p_pkg;

  // Width of the internal angle accumulator, in units of 2^-32 turn.
  localparam int unsigned ZW = 32;

  localparam logic [ZW-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) / (2*pi), in units of 2^-32 turn.
  localparam logic [ZW-1:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Per-stage side band: occupancy plus the quadrant and degenerate-case marks.
  typedef struct packed {
    logic valid;
    logic neg_x;
    logic neg_y;
    logic coinc;
  } flags_t;

endpackage

`default_nettype wire

### sv/c2p_if.sv
`default_nettype none

interface c2p_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface c2p_out_if #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic [COORD_WIDTH:0]   distance;
  logic [ANGLE_WIDTH-1:0] direction;
  logic                   coincident;

  modport source (output valid, distance, direction, coincident, input ready);
  modport sink   (input valid, distance, direction, coincident, output ready);
endinterface

`default_nettype wire

### sv/c2p_stage.sv
`default_nettype none

// One pipeline step: one CORDIC micro-rotation (if DO_ROT) and one square-root digit (if DO_SQ).
module c2p_stage import c2p_pkg::*; #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned XW     = 63,
  parameter int unsigned SW     = 34,
  parameter int unsigned NP     = 17,
  parameter int unsigned RW     = 20,
  parameter bit          DO_ROT = 1'b1,
  parameter bit          DO_SQ  = 1'b1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire flags_t               flags_i,
  input  wire logic signed [XW-1:0] x_i,
  input  wire logic signed [XW-1:0] y_i,
  input  wire logic [ZW-1:0]        z_i,
  input  wire logic [SW-1:0]        s_i,
  input  wire logic [RW-1:0]        rem_i,
  input  wire logic [NP-1:0]        root_i,
  output flags_t                    flags_o,
  output logic signed [XW-1:0]      x_o,
  output logic signed [XW-1:0]      y_o,
  output logic [ZW-1:0]             z_o,
  output logic [SW-1:0]             s_o,
  output logic [RW-1:0]             rem_o,
  output logic [NP-1:0]             root_o
);

  flags_t               flags_q;
  logic signed [XW-1:0] x_d, y_d, x_q, y_q;
  logic [ZW-1:0]        z_d, z_q;
  logic [SW-1:0]        s_d, s_q;
  logic [RW-1:0]        rem_d, rem_q;
  logic [NP-1:0]        root_d, root_q;

  generate
    if (DO_ROT) begin : g_rot
      logic signed [XW-1:0] xs, ys;
      assign xs = x_i >>> IDX;
      assign ys = y_i >>> IDX;
      always_comb begin
        if (!y_i[XW-1]) begin
          x_d = x_i + ys;
          y_d = y_i - xs;
          z_d = z_i + ATAN_TURN[IDX];
        end else begin
          x_d = x_i - ys;
          y_d = y_i + xs;
          z_d = z_i - ATAN_TURN[IDX];
        end
      end
    end else begin : g_no_rot
      assign x_d = x_i;
      assign y_d = y_i;
      assign z_d = z_i;
    end

    if (DO_SQ) begin : g_sq
      logic [RW-1:0] rem_sh, trial;
      // Bring down the next bit pair and try root*4+1 against it.
      assign rem_sh = {rem_i[RW-3:0], s_i[SW-1 -: 2]};
      assign trial  = {{(RW-NP-2){1'b0}}, root_i, 2'b01};
      always_comb begin
        s_d = {s_i[SW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_i[NP-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_i[NP-2:0], 1'b0};
        end
      end
    end else begin : g_no_sq
      assign s_d    = s_i;
      assign rem_d  = rem_i;
      assign root_d = root_i;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (en_i) begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      s_q    <= s_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign flags_o = flags_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign s_o     = s_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule

`default_nettype wire

### sv/cartesian_to_polar.sv
`default_nettype none

// Cartesian-to-polar converter. Each input transaction carries a start and an
// end point (signed fixed point, Q8.8 at the default width); the result
// transaction gives the rounded Euclidean distance (unsigned, one integer bit
// wider), the direction from start to end as an unsigned fraction of a full
// turn in [0, 1) rounded to ANGLE_WIDTH bits (a full turn wraps to zero), and
// a coincident flag. When the points are equal, coincident is 1 and distance
// and direction are 0. The datapath is a single pipeline: input register,
// absolute value, squaring, sum, then max(ITERATIONS, COORD_WIDTH+1) steps
// that each run at most one CORDIC micro-rotation and one square-root bit,
// then a rounding/quadrant step and the output register. One transaction is
// accepted every cycle while the output is not stalled. A stalled output
// freezes every stage at once, so in_i.ready is high whenever the output
// register is empty or being drained.
module cartesian_to_polar import c2p_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 16,
  parameter int unsigned ANGLE_WIDTH = 16,
  parameter int unsigned ITERATIONS  = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  c2p_in_if.sink     in_i,
  c2p_out_if.source  out_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned AW    = ANGLE_WIDTH;
  localparam int unsigned GUARD = 60 - CW;
  // CORDIC registers: |d| scaled by 2^GUARD, times gain and sqrt(2), plus sign.
  localparam int unsigned XW    = GUARD + CW + 3;
  localparam int unsigned SW    = 2 * CW + 2;       // sum of squares
  localparam int unsigned NP    = CW + 1;           // root bits
  localparam int unsigned RW    = NP + 3;           // partial remainder
  localparam int unsigned NST   = (ITERATIONS > NP) ? ITERATIONS : NP;
  localparam int unsigned SH    = ZW - AW;          // angle bits dropped

  // Global advance: move everything when the output register can take data.
  logic en;
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // Stage 0: form the difference vector.
  flags_t               f0_q;
  logic signed [CW:0]   dx_q, dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_q <= '0;
    end else if (en) begin
      f0_q <= '{valid: in_i.valid, neg_x: 1'b0, neg_y: 1'b0, coinc: 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= {in_i.end_x[CW-1], in_i.end_x} - {in_i.start_x[CW-1], in_i.start_x};
      dy_q <= {in_i.end_y[CW-1], in_i.end_y} - {in_i.start_y[CW-1], in_i.start_y};
    end
  end

  // Stage 1: magnitudes, quadrant marks and the coincidence mark.
  flags_t      f1_q;
  logic [CW:0] ax_q, ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
    end else if (en) begin
      f1_q <= '{valid: f0_q.valid, neg_x: dx_q[CW], neg_y: dy_q[CW],
                coinc: (dx_q == '0) && (dy_q == '0)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q <= dx_q[CW] ? (CW+1)'(0) - dx_q : dx_q;
      ay_q <= dy_q[CW] ? (CW+1)'(0) - dy_q : dy_q;
    end
  end

  // Stage 2: squares, and load the CORDIC vector.
  flags_t               f2_q;
  logic [SW-1:0]        sx_q, sy_q;
  logic signed [XW-1:0] x2_q, y2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_q <= '0;
    end else if (en) begin
      f2_q <= f1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= ax_q * ax_q;
      sy_q <= ay_q * ay_q;
      x2_q <= {2'b00, ax_q, {GUARD{1'b0}}};
      y2_q <= {2'b00, ay_q, {GUARD{1'b0}}};
    end
  end

  // Stage 3: sum of squares; the vector rides along.
  flags_t               f3_q;
  logic [SW:0]          sum;
  logic [SW-1:0]        s3_q;
  logic signed [XW-1:0] x3_q, y3_q;

  assign sum = {1'b0, sx_q} + {1'b0, sy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f3_q <= '0;
    end else if (en) begin
      f3_q <= f2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= sum[SW-1:0];   // at most 2^(2*CW+1), fits
      x3_q <= x2_q;
      y3_q <= y2_q;
    end
  end

  // Iteration chain: rotation i and root digit i in step i.
  flags_t               fc   [NST+1];
  logic signed [XW-1:0] xc   [NST+1];
  logic signed [XW-1:0] yc   [NST+1];
  logic [ZW-1:0]        zc   [NST+1];
  logic [SW-1:0]        sc   [NST+1];
  logic [RW-1:0]        remc [NST+1];
  logic [NP-1:0]        rootc[NST+1];

  assign fc[0]    = f3_q;
  assign xc[0]    = x3_q;
  assign yc[0]    = y3_q;
  assign zc[0]    = '0;
  assign sc[0]    = s3_q;
  assign remc[0]  = '0;
  assign rootc[0] = '0;

  generate
    for (genvar k = 0; k < NST; k++) begin : g_step
      c2p_stage #(
        .IDX    (k),
        .XW     (XW),
        .SW     (SW),
        .NP     (NP),
        .RW     (RW),
        .DO_ROT (k < ITERATIONS),
        .DO_SQ  (k < NP)
      ) u_stage (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .flags_i (fc[k]),
        .x_i     (xc[k]),
        .y_i     (yc[k]),
        .z_i     (zc[k]),
        .s_i     (sc[k]),
        .rem_i   (remc[k]),
        .root_i  (rootc[k]),
        .flags_o (fc[k+1]),
        .x_o     (xc[k+1]),
        .y_o     (yc[k+1]),
        .z_o     (zc[k+1]),
        .s_o     (sc[k+1]),
        .rem_o   (remc[k+1]),
        .root_o  (rootc[k+1])
      );
    end
  endgenerate

  // Round step: round the root half up, unfold the angle into its quadrant.
  flags_t        fr_q;
  logic [NP-1:0] root_fin, dist_q;
  logic [ZW-1:0] z_fin, theta_d, theta_q;

  assign root_fin = rootc[NST];
  assign z_fin    = zc[NST];

  always_comb begin
    case ({fc[NST].neg_y, fc[NST].neg_x})
      2'b00:   theta_d = z_fin;
      2'b01:   theta_d = HALF_TURN - z_fin;
      2'b11:   theta_d = HALF_TURN + z_fin;
      2'b10:   theta_d = ZW'(0) - z_fin;
      default: theta_d = z_fin;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_q <= '0;
    end else if (en) begin
      fr_q <= fc[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q  <= (remc[NST] > {{(RW-NP){1'b0}}, root_fin}) ? root_fin + 1'b1 : root_fin;
      theta_q <= theta_d;
    end
  end

  // Output register: drop the angle to AW bits, half up; a full turn wraps.
  logic [AW-1:0] dir_d;

  generate
    if (SH > 0) begin : g_round
      logic [ZW:0] t_sum;
      assign t_sum = {1'b0, theta_q} + ((ZW+1)'(1) << (SH - 1));
      assign dir_d = t_sum[SH +: AW];
    end else begin : g_full
      assign dir_d = theta_q[AW-1:0];
    end
  endgenerate

  logic           out_valid_q;
  logic [CW:0]    distance_q;
  logic [AW-1:0]  direction_q;
  logic           coinc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= fr_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      coinc_q     <= fr_q.coinc;
      distance_q  <= fr_q.coinc ? '0 : dist_q;
      direction_q <= fr_q.coinc ? '0 : dir_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.distance   = distance_q;
  assign out_o.direction  = direction_q;
  assign out_o.coincident = coinc_q;

  // A degenerate vector must report zero distance and zero direction.
  a_coinc_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.coincident) |-> (out_o.distance == '0 && out_o.direction == '0))
    else $error("coincident result with nonzero distance or direction");

  // Any nonzero difference has a root of at least one LSB.
  a_dist_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.coincident) |-> (out_o.distance != '0))
    else $error("nonzero difference produced zero distance");

  // A stall freezes the pipeline occupancy deep inside the chain.
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(fc[NST].valid) && $stable(fr_q.valid) && $stable(f3_q.valid)))
    else $error("pipeline occupancy changed during a stall");

  // A zero difference vector carries no negative quadrant mark.
  a_coinc_has_no_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fr_q.valid && fr_q.coinc) |-> (!fr_q.neg_x && !fr_q.neg_y))
    else $error("coincident transaction carries a negative quadrant mark");

endmodule

`default_nettype wire
